// ===== src/gdbc_pkg.sv =====
// Shared types and constants for the Gregorian day-difference counter.
package gdbc_pkg;

   localparam int COUNT_W     = 22;
   localparam int RSP_W       = 24;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 22'd4194303;

   // Year reduction: 16-bit working width covers the widest year field,
   // weights 400<<7 down to 400<<0, one weight per cycle.
   localparam int RED_W       = 16;
   localparam int RED_STEPS   = 8;
   localparam int RED_STEP_W  = 3;
   localparam int RES_W       = 9;
   localparam logic [RED_W-1:0] YEAR_CYCLE = 16'd400;
   localparam logic [RES_W-1:0] CYCLE_LAST = 9'd399;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic load;
      logic reduce;
      logic setup;
      logic step;
      logic publish;
   } gdbc_cmd_type;

   typedef struct packed {
      logic reduce_last;
      logic dates_ok;
      logic walk_done;
      logic out_free;
   } gdbc_sts_type;

   // Leap test from the year's residue modulo 400.
   function automatic logic is_leap(input logic [RES_W-1:0] res);
      logic leap;
      if (res == '0) begin
         leap = 1'b1;
      end else if (res == 9'd100 || res == 9'd200 || res == 9'd300) begin
         leap = 1'b0;
      end else begin
         leap = (res[1:0] == 2'b00);
      end
      return leap;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
         len = 5'd30;
      end else if (month == MONTH_FEB) begin
         len = leap ? 5'd29 : 5'd28;
      end else begin
         len = 5'd31;
      end
      return len;
   endfunction

   function automatic logic date_ok(input logic [4:0] day, input logic [3:0] month,
                                    input logic [RES_W-1:0] res);
      logic ok;
      if (month < MONTH_JAN || month > MONTH_DEC || day == '0) begin
         ok = 1'b0;
      end else begin
         ok = (day <= month_len(month, is_leap(res)));
      end
      return ok;
   endfunction

endpackage

// ===== src/gregorian_days_between_counter_top.sv =====
// Gregorian day-difference counter, top level.
//
// Input channel req_*: one word carries two dates; the block returns on rsp_*
// the number of days from the earlier date to the later one, with rsp_tuser
// set (and a count of zero) when either date is not a real calendar date.
// Dates are ordered by full year-month-day; equal dates give zero.
//
// The word is taken when req_tvalid and req_tready are high. Both years are
// reduced modulo 400 by compare-subtract steps, a check state follows, then
// the walker advances the earlier date one day per cycle. The count is
// capped at 4194303, where the walk stops. The single day walker handles one
// word at a time: the next word is taken only once the last result has gone
// into the output register.
//
// The result sits in an output register, so the next input word is taken
// while it waits. If the receiver stalls, the finished count is held inside
// until the output register frees. Reset returns to idle and drops rsp_tvalid.
module gregorian_days_between_counter_top
   import gdbc_pkg::*;
#(
   parameter int YEAR_BITS = 14
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // first_day, first_month, first_year, second_day, second_month, second_year
   input  logic [((2 * (9 + YEAR_BITS) + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [RSP_W-1:0]                       rsp_tdata,  // day_count
   output logic                                   rsp_tuser   // invalid
);

   localparam int REQ_W = ((2 * (9 + YEAR_BITS) + 7) / 8) * 8;

   gdbc_cmd_type cmd;
   gdbc_sts_type sts;

   gdbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gdbc_datapath #(
      .YEAR_BITS (YEAR_BITS),
      .REQ_W     (REQ_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== src/gdbc_ctrl.sv =====
// Sequencer for the day-difference counter: load, reduce, check, walk, publish.
module gdbc_ctrl
   import gdbc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  gdbc_sts_type sts,
   output gdbc_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_CHECK  = 5'b00100,
      ST_WALK   = 5'b01000,
      ST_FINISH = 5'b10000
   } gdbc_state_type;

   gdbc_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (sts.reduce_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.setup = 1'b1;
            state_in  = sts.dates_ok ? ST_WALK : ST_FINISH;
         end
         ST_WALK: begin
            if (sts.walk_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/gdbc_datapath.sv =====
// Date registers, year reduction, validity/ordering and the one-day walker.
module gdbc_datapath
   import gdbc_pkg::*;
#(
   parameter int YEAR_BITS = 14,
   parameter int REQ_W     = 48
) (
   input  logic               clock,
   input  logic               reset,
   input  gdbc_cmd_type       cmd,
   output gdbc_sts_type       sts,
   input  logic [REQ_W-1:0]   req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,
   output logic               rsp_tuser
);

   localparam int KEY_W  = YEAR_BITS + 9;
   localparam int D1_LSB = 0;
   localparam int M1_LSB = 5;
   localparam int Y1_LSB = 9;
   localparam int D2_LSB = 9 + YEAR_BITS;
   localparam int M2_LSB = 14 + YEAR_BITS;
   localparam int Y2_LSB = 18 + YEAR_BITS;

   logic [4:0]           d1_ff, d2_ff;
   logic [3:0]           m1_ff, m2_ff;
   logic [YEAR_BITS-1:0] y1_ff, y2_ff;
   logic [RED_W-1:0]     res1_ff, res1_in, res2_ff, res2_in, weight;
   logic [RED_STEP_W-1:0] red_step_ff;

   logic [4:0]           walk_day_ff, walk_day_in;
   logic [3:0]           walk_month_ff, walk_month_in;
   logic [YEAR_BITS-1:0] walk_year_ff, walk_year_in;
   logic [RES_W-1:0]     walk_res_ff, walk_res_in;
   logic [KEY_W-1:0]     goal_ff, key1, key2;
   logic [COUNT_W-1:0]   count_ff;
   logic                 inv_ff;

   logic                 rsp_valid_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_inv_ff;

   logic                 ok1, ok2, swap;

   // One compare-subtract per cycle against 400 shifted by the step index
   assign weight  = YEAR_CYCLE << red_step_ff;
   assign res1_in = (res1_ff >= weight) ? res1_ff - weight : res1_ff;
   assign res2_in = (res2_ff >= weight) ? res2_ff - weight : res2_ff;

   assign ok1  = date_ok(d1_ff, m1_ff, res1_ff[RES_W-1:0]);
   assign ok2  = date_ok(d2_ff, m2_ff, res2_ff[RES_W-1:0]);
   assign key1 = {y1_ff, m1_ff, d1_ff};
   assign key2 = {y2_ff, m2_ff, d2_ff};
   assign swap = (key2 < key1);

   // Next day of the walk
   always_comb begin
      walk_day_in   = walk_day_ff + 5'd1;
      walk_month_in = walk_month_ff;
      walk_year_in  = walk_year_ff;
      walk_res_in   = walk_res_ff;
      if (walk_day_ff == month_len(walk_month_ff, is_leap(walk_res_ff))) begin
         walk_day_in = 5'd1;
         if (walk_month_ff == MONTH_DEC) begin
            walk_month_in = MONTH_JAN;
            walk_year_in  = walk_year_ff + 1'b1;
            walk_res_in   = (walk_res_ff == CYCLE_LAST) ? '0 : walk_res_ff + 1'b1;
         end else begin
            walk_month_in = walk_month_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         d1_ff   <= req_tdata[D1_LSB +: 5];
         m1_ff   <= req_tdata[M1_LSB +: 4];
         y1_ff   <= req_tdata[Y1_LSB +: YEAR_BITS];
         d2_ff   <= req_tdata[D2_LSB +: 5];
         m2_ff   <= req_tdata[M2_LSB +: 4];
         y2_ff   <= req_tdata[Y2_LSB +: YEAR_BITS];
         res1_ff <= RED_W'(req_tdata[Y1_LSB +: YEAR_BITS]);
         res2_ff <= RED_W'(req_tdata[Y2_LSB +: YEAR_BITS]);
      end else if (cmd.reduce) begin
         res1_ff <= res1_in;
         res2_ff <= res2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_step_ff <= RED_STEP_W'(RED_STEPS - 1);
      end else if (cmd.load) begin
         red_step_ff <= RED_STEP_W'(RED_STEPS - 1);
      end else if (cmd.reduce) begin
         red_step_ff <= red_step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_day_ff   <= 5'd1;
         walk_month_ff <= MONTH_JAN;
         walk_year_ff  <= '0;
         walk_res_ff   <= '0;
         goal_ff       <= '0;
         count_ff      <= '0;
         inv_ff        <= 1'b0;
      end else if (cmd.setup) begin
         inv_ff   <= !(ok1 && ok2);
         count_ff <= '0;
         if (ok1 && ok2) begin
            if (swap) begin
               walk_day_ff   <= d2_ff;
               walk_month_ff <= m2_ff;
               walk_year_ff  <= y2_ff;
               walk_res_ff   <= res2_ff[RES_W-1:0];
               goal_ff       <= key1;
            end else begin
               walk_day_ff   <= d1_ff;
               walk_month_ff <= m1_ff;
               walk_year_ff  <= y1_ff;
               walk_res_ff   <= res1_ff[RES_W-1:0];
               goal_ff       <= key2;
            end
         end
      end else if (cmd.step) begin
         walk_day_ff   <= walk_day_in;
         walk_month_ff <= walk_month_in;
         walk_year_ff  <= walk_year_in;
         walk_res_ff   <= walk_res_in;
         count_ff      <= count_ff + 1'b1;
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_count_ff <= inv_ff ? '0 : count_ff;
         rsp_inv_ff   <= inv_ff;
      end
   end

   assign sts.reduce_last = (red_step_ff == '0);
   assign sts.dates_ok    = ok1 && ok2;
   // saturated count stops the walk early
   assign sts.walk_done   = ({walk_year_ff, walk_month_ff, walk_day_ff} == goal_ff) ||
                            (count_ff == COUNT_MAX);
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - COUNT_W){1'b0}}, rsp_count_ff};
   assign rsp_tuser  = rsp_inv_ff;

endmodule

// ===== src/gdbc_checker.sv =====
// Port-level checks for the day-difference counter, bound to the top level.
module gdbc_checker
   import gdbc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tuser
);

   // a waiting result word is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[COUNT_W-1:0] == '0)
      else $error("invalid date with non-zero count");

   // year reduction keeps the block busy after taking a word
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again straight after a word");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      $past(req_tvalid && req_tready) && !$past(rsp_tvalid) |-> !rsp_tvalid)
      else $error("result appeared the cycle after its input");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind gregorian_days_between_counter_top gdbc_checker u_gdbc_checker (.*);
